### rtl/core/kmeans_lloyd_cluster_top_defines.svh
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef KMEANS_LLOYD_CLUSTER_TOP_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTER_TOP_DEFINES_SVH

// same-cycle implication
`define KML_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KML_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/kml_pkg.sv
`default_nettype none

package kml_pkg;

    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_PICK = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_SQ   = 3'd4;

    localparam logic [3:0]  RST_NUM_CLUSTERS = 4'd1;
    localparam logic [3:0]  RST_DIMENSION    = 4'd1;
    localparam logic [12:0] RST_NUM_POINTS   = 13'd1;
    localparam logic [15:0] RST_MAX_ITER     = 16'd300;
    localparam logic [47:0] RST_EPSILON_SQ   = 48'd4295;

    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        point_index;
        logic [2:0]         coord_index;
        logic signed [31:0] coord_value;
        logic [2:0]         cluster_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_cluster;
        logic [2:0]         out_coord;
        logic signed [31:0] centroid_value;
        logic               converged;
        logic               last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CP_RD,
        ST_CP_WR,
        ST_CLR,
        ST_A_RD,
        ST_A_DIFF,
        ST_A_MUL,
        ST_A_ACC,
        ST_A_BEST,
        ST_S_RD,
        ST_S_WR,
        ST_U_CHK,
        ST_U_RD,
        ST_U_DIV,
        ST_U_WAIT,
        ST_U_DIFF,
        ST_U_MUL,
        ST_U_ACC,
        ST_U_MOVE,
        ST_U_NEXT,
        ST_R_END,
        ST_E_RD,
        ST_E_LOAD,
        ST_E_WAIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_RUN,
        OP_CP_RD,
        OP_CP_WR,
        OP_CLR,
        OP_A_RD,
        OP_A_DIFF,
        OP_A_MUL,
        OP_A_ACC,
        OP_A_BEST,
        OP_S_RD,
        OP_S_WR,
        OP_U_CHK,
        OP_U_RD,
        OP_U_DIV,
        OP_U_DIFF,
        OP_U_MUL,
        OP_U_ACC,
        OP_U_MOVE,
        OP_R_END,
        OP_E_RD,
        OP_E_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cnt_zero;
        logic moved;
        logic out_fire;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/kml_div.sv
`default_nettype none

module kml_div #(
    parameter int DVD_W = 45,
    parameter int DVS_W = 13,
    localparam int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    busy,
    output logic signed [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    // restoring division on magnitudes, one quotient bit a cycle
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[DVD_W-1]};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        rem_next = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        q_next   = {q_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[DVD_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DVD_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -q_reg : q_reg;

endmodule

`default_nettype wire

### rtl/core/kml_dp.sv
`default_nettype none
`include "kmeans_lloyd_cluster_top_defines.svh"

module kml_dp #(
    parameter int MAX_POINTS   = 4096,
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIM      = 8,
    localparam int P_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int C_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int J_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kml_pkg::in_item_t   in_item,
    input  kml_pkg::dp_cmd_t    cmd,
    input  logic [P_W-1:0]      p_idx,
    input  logic [C_W-1:0]      c_idx,
    input  logic [J_W-1:0]      j_idx,
    input  logic [47:0]         eps,
    output kml_pkg::dp_stat_t   stat,
    output logic                out_valid,
    input  logic                out_stall,
    output kml_pkg::out_item_t  out_item
);

    import kml_pkg::*;

    localparam int PDEPTH = MAX_POINTS * MAX_DIM;
    localparam int CDEPTH = MAX_CLUSTERS * MAX_DIM;
    localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SUM_W  = 32 + P_W + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ACC_W  = 64 + $clog2(MAX_DIM);

    logic signed [31:0]    pmem [PDEPTH];
    logic signed [31:0]    cmem [CDEPTH];
    logic signed [SUM_W-1:0] smem [CDEPTH];

    logic signed [31:0]    pm_rd_reg;
    logic signed [31:0]    cm_rd_reg;
    logic signed [SUM_W-1:0] sm_rd_reg;

    logic [PA_W-1:0]       pa_rd, pa_wr;
    logic [CA_W-1:0]       ca, sa;
    logic [C_W-1:0]        sa_c, cnt_idx;

    logic [CNT_W-1:0]      cnt_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]      cnt_sel;

    logic [31:0]           mag_reg;
    logic [63:0]           sq_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      best_reg;
    logic [C_W-1:0]        best_c_reg;
    logic                  moved_reg;
    logic                  conv_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    logic signed [31:0]    dif_a, dif_b;
    logic signed [32:0]    diff, diff_neg;
    logic [31:0]           mag_next;
    logic signed [31:0]    mean;
    logic signed [SUM_W-1:0] sum_next;

    logic                  div_busy;
    logic signed [SUM_W-1:0] quot;
    logic                  out_fire;

    // addressing
    always_comb
    begin
        pa_rd   = PA_W'(p_idx) * PA_W'(MAX_DIM) + PA_W'(j_idx);
        pa_wr   = PA_W'(P_W'(in_item.point_index)) * PA_W'(MAX_DIM)
                  + PA_W'(in_item.coord_index);
        ca      = CA_W'(c_idx) * CA_W'(MAX_DIM) + CA_W'(j_idx);
        sa_c    = (cmd.op inside {OP_S_RD, OP_S_WR}) ? best_c_reg : c_idx;
        sa      = CA_W'(sa_c) * CA_W'(MAX_DIM) + CA_W'(j_idx);
        cnt_idx = (cmd.op == OP_S_WR) ? best_c_reg : c_idx;
        cnt_sel = cnt_reg[cnt_idx];
    end

    // point memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            pmem[pa_wr] <= in_item.coord_value;
        end
        if (cmd.op inside {OP_CP_RD, OP_A_RD, OP_S_RD})
        begin
            pm_rd_reg <= pmem[pa_rd];
        end
    end

    // centroid memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CP_WR)
        begin
            cmem[ca] <= pm_rd_reg;
        end
        else if (cmd.op == OP_U_DIFF)
        begin
            cmem[ca] <= mean;
        end
        if (cmd.op inside {OP_A_RD, OP_U_RD, OP_E_RD})
        begin
            cm_rd_reg <= cmem[ca];
        end
    end

    assign sum_next = sm_rd_reg + {{(SUM_W-32){pm_rd_reg[31]}}, pm_rd_reg};

    // per-coordinate sum memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
        begin
            smem[sa] <= '0;
        end
        else if (cmd.op == OP_S_WR)
        begin
            smem[sa] <= sum_next;
        end
        if (cmd.op inside {OP_S_RD, OP_U_RD})
        begin
            sm_rd_reg <= smem[sa];
        end
    end

    // membership counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_CLR)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_S_WR && j_idx == '0)
        begin
            cnt_reg[cnt_idx] <= cnt_sel + 1'b1;
        end
    end

    kml_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_U_DIV),
        .dividend (sm_rd_reg),
        .divisor  (cnt_sel),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign mean = quot[31:0];

    // shared |a - b|; update compares new mean against old centroid
    always_comb
    begin
        dif_a    = (cmd.op == OP_U_DIFF) ? mean : cm_rd_reg;
        dif_b    = (cmd.op == OP_U_DIFF) ? cm_rd_reg : pm_rd_reg;
        diff     = {dif_a[31], dif_a} - {dif_b[31], dif_b};
        diff_neg = -diff;
        mag_next = diff[32] ? diff_neg[31:0] : diff[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op inside {OP_A_DIFF, OP_U_DIFF})
        begin
            mag_reg <= mag_next;
        end
        if (cmd.op inside {OP_A_MUL, OP_U_MUL})
        begin
            sq_reg <= 64'(mag_reg) * 64'(mag_reg);
        end
        if ((cmd.op == OP_A_RD && j_idx == '0) || cmd.op == OP_U_CHK)
        begin
            acc_reg <= '0;
        end
        else if (cmd.op inside {OP_A_ACC, OP_U_ACC})
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        if (cmd.op == OP_A_BEST && (c_idx == '0 || acc_reg < best_reg))
        begin
            best_reg   <= acc_reg;
            best_c_reg <= c_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moved_reg <= 1'b0;
            conv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLR)
            begin
                moved_reg <= 1'b0;
            end
            else if (cmd.op == OP_U_MOVE && acc_reg >= ACC_W'(eps))
            begin
                moved_reg <= 1'b1;
            end
            if (cmd.op == OP_RUN)
            begin
                conv_reg <= 1'b0;
            end
            else if (cmd.op == OP_R_END)
            begin
                conv_reg <= !moved_reg;
            end
        end
    end

    // output register
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_E_LOAD)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_E_LOAD)
        begin
            out_item_reg.out_cluster    <= 3'(c_idx);
            out_item_reg.out_coord      <= 3'(j_idx);
            out_item_reg.centroid_value <= cm_rd_reg;
            out_item_reg.converged      <= conv_reg;
            out_item_reg.last           <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        stat.div_busy = div_busy;
        stat.cnt_zero = (cnt_sel == '0);
        stat.moved    = moved_reg;
        stat.out_fire = out_fire;
    end

    `KML_ASSERT_NOW(a_div_idle, cmd.op == OP_U_DIV, !div_busy, "divider restarted while busy")
    `KML_ASSERT_NOW(a_div_nonzero, cmd.op == OP_U_DIV, cnt_sel != '0, "divide by empty cluster")
    `KML_ASSERT_NOW(a_out_free, cmd.op == OP_E_LOAD, !out_valid_reg, "output overwritten")

endmodule

`default_nettype wire

### rtl/core/kml_ctrl.sv
`default_nettype none

module kml_ctrl #(
    parameter int MAX_POINTS   = 4096,
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIM      = 8,
    localparam int P_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int C_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int J_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  kml_pkg::in_item_t              in_item,
    input  logic                           cfg_we,
    input  logic [kml_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kml_pkg::CFG_W-1:0]      cfg_data,
    input  kml_pkg::dp_stat_t              stat,
    output kml_pkg::dp_cmd_t               cmd,
    output logic [P_W-1:0]                 p_idx,
    output logic [C_W-1:0]                 c_idx,
    output logic [J_W-1:0]                 j_idx,
    output logic [47:0]                    eps
);

    import kml_pkg::*;

    ctrl_state_t    state_reg, state_next;
    logic [P_W-1:0] p_reg, p_next;
    logic [C_W-1:0] c_reg, c_next;
    logic [J_W-1:0] j_reg, j_next;
    logic [15:0]    it_reg, it_next;

    logic [3:0]     nclu_reg;
    logic [3:0]     dim_reg;
    logic [12:0]    npts_reg;
    logic [15:0]    maxit_reg;
    logic [47:0]    eps_reg;

    logic [C_W-1:0] k_last;
    logic [J_W-1:0] d_last;
    logic [P_W-1:0] n_last;
    logic           load_ok, pick_ok;
    logic           j_end, c_end, at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nclu_reg  <= RST_NUM_CLUSTERS;
            dim_reg   <= RST_DIMENSION;
            npts_reg  <= RST_NUM_POINTS;
            maxit_reg <= RST_MAX_ITER;
            eps_reg   <= RST_EPSILON_SQ;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_CLUSTERS: nclu_reg  <= cfg_data[3:0];
                CFG_DIMENSION:    dim_reg   <= cfg_data[3:0];
                CFG_NUM_POINTS:   npts_reg  <= cfg_data[12:0];
                CFG_MAX_ITER:     maxit_reg <= cfg_data[15:0];
                CFG_EPSILON_SQ:   eps_reg   <= cfg_data[47:0];
                default:          ;
            endcase
        end
    end

    // loop bounds, saturated into the supported range
    always_comb
    begin
        if (nclu_reg == '0)
            k_last = '0;
        else if (32'(nclu_reg) > MAX_CLUSTERS)
            k_last = C_W'(MAX_CLUSTERS - 1);
        else
            k_last = C_W'(nclu_reg - 4'd1);

        if (dim_reg == '0)
            d_last = '0;
        else if (32'(dim_reg) > MAX_DIM)
            d_last = J_W'(MAX_DIM - 1);
        else
            d_last = J_W'(dim_reg - 4'd1);

        if (npts_reg == '0)
            n_last = '0;
        else if (32'(npts_reg) > MAX_POINTS)
            n_last = P_W'(MAX_POINTS - 1);
        else
            n_last = P_W'(npts_reg - 13'd1);

        load_ok = (32'(in_item.point_index) < MAX_POINTS)
                  && (32'(in_item.coord_index) < MAX_DIM);
        pick_ok = (32'(in_item.point_index) < MAX_POINTS)
                  && (32'(in_item.cluster_index) < MAX_CLUSTERS);
        j_end   = (j_reg == d_last);
        c_end   = (c_reg == k_last);
        at_end  = j_end && c_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= '0;
            c_reg     <= '0;
            j_reg     <= '0;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            c_reg     <= c_next;
            j_reg     <= j_next;
            it_reg    <= it_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        j_next     = j_reg;
        it_next    = it_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.mode)
                        MODE_PICK:
                        begin
                            if (pick_ok)
                            begin
                                p_next     = P_W'(in_item.point_index);
                                c_next     = C_W'(in_item.cluster_index);
                                j_next     = '0;
                                state_next = ST_CP_RD;
                            end
                        end
                        MODE_RUN:
                        begin
                            p_next     = '0;
                            c_next     = '0;
                            j_next     = '0;
                            it_next    = '0;
                            state_next = (maxit_reg == '0) ? ST_E_RD : ST_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CP_RD: state_next = ST_CP_WR;
            ST_CP_WR:
            begin
                if (j_reg == J_W'(MAX_DIM - 1))
                begin
                    j_next     = '0;
                    c_next     = '0;
                    p_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CP_RD;
                end
            end
            ST_CLR:
            begin
                if (j_reg == J_W'(MAX_DIM - 1))
                begin
                    j_next = '0;
                    if (c_reg == C_W'(MAX_CLUSTERS - 1))
                    begin
                        c_next     = '0;
                        p_next     = '0;
                        state_next = ST_A_RD;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_A_RD:   state_next = ST_A_DIFF;
            ST_A_DIFF: state_next = ST_A_MUL;
            ST_A_MUL:  state_next = ST_A_ACC;
            ST_A_ACC:
            begin
                if (j_end)
                begin
                    j_next     = '0;
                    state_next = ST_A_BEST;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_A_RD;
                end
            end
            ST_A_BEST:
            begin
                if (c_end)
                begin
                    c_next     = '0;
                    state_next = ST_S_RD;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_A_RD;
                end
            end
            ST_S_RD: state_next = ST_S_WR;
            ST_S_WR:
            begin
                if (j_end)
                begin
                    j_next = '0;
                    if (p_reg == n_last)
                    begin
                        p_next     = '0;
                        state_next = ST_U_CHK;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_A_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_U_CHK:  state_next = stat.cnt_zero ? ST_U_NEXT : ST_U_RD;
            ST_U_RD:   state_next = ST_U_DIV;
            ST_U_DIV:  state_next = ST_U_WAIT;
            ST_U_WAIT: state_next = stat.div_busy ? ST_U_WAIT : ST_U_DIFF;
            ST_U_DIFF: state_next = ST_U_MUL;
            ST_U_MUL:  state_next = ST_U_ACC;
            ST_U_ACC:
            begin
                if (j_end)
                begin
                    j_next     = '0;
                    state_next = ST_U_MOVE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_U_RD;
                end
            end
            ST_U_MOVE: state_next = ST_U_NEXT;
            ST_U_NEXT:
            begin
                if (c_end)
                begin
                    c_next     = '0;
                    state_next = ST_R_END;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_U_CHK;
                end
            end
            ST_R_END:
            begin
                if (!stat.moved || it_reg == maxit_reg - 16'd1)
                begin
                    state_next = ST_E_RD;
                end
                else
                begin
                    it_next    = it_reg + 16'd1;
                    state_next = ST_CLR;
                end
            end
            ST_E_RD:   state_next = ST_E_LOAD;
            ST_E_LOAD: state_next = ST_E_WAIT;
            ST_E_WAIT:
            begin
                if (stat.out_fire)
                begin
                    if (at_end)
                    begin
                        c_next     = '0;
                        j_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else if (j_end)
                    begin
                        j_next     = '0;
                        c_next     = c_reg + 1'b1;
                        state_next = ST_E_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_E_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd.op   = OP_NOP;
        cmd.last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_item.mode == MODE_LOAD && load_ok)
                    cmd.op = OP_LOAD;
                else if (in_valid && in_item.mode == MODE_RUN)
                    cmd.op = OP_RUN;
            end
            ST_CP_RD:  cmd.op = OP_CP_RD;
            ST_CP_WR:  cmd.op = OP_CP_WR;
            ST_CLR:    cmd.op = OP_CLR;
            ST_A_RD:   cmd.op = OP_A_RD;
            ST_A_DIFF: cmd.op = OP_A_DIFF;
            ST_A_MUL:  cmd.op = OP_A_MUL;
            ST_A_ACC:  cmd.op = OP_A_ACC;
            ST_A_BEST: cmd.op = OP_A_BEST;
            ST_S_RD:   cmd.op = OP_S_RD;
            ST_S_WR:   cmd.op = OP_S_WR;
            ST_U_CHK:  cmd.op = OP_U_CHK;
            ST_U_RD:   cmd.op = OP_U_RD;
            ST_U_DIV:  cmd.op = OP_U_DIV;
            ST_U_DIFF: cmd.op = OP_U_DIFF;
            ST_U_MUL:  cmd.op = OP_U_MUL;
            ST_U_ACC:  cmd.op = OP_U_ACC;
            ST_U_MOVE: cmd.op = OP_U_MOVE;
            ST_R_END:  cmd.op = OP_R_END;
            ST_E_RD:   cmd.op = OP_E_RD;
            ST_E_LOAD:
            begin
                cmd.op   = OP_E_LOAD;
                cmd.last = at_end;
            end
            default:   cmd.op = OP_NOP;
        endcase
        in_stall = (state_reg != ST_IDLE);
    end

    assign p_idx = p_reg;
    assign c_idx = c_reg;
    assign j_idx = j_reg;
    assign eps   = eps_reg;

endmodule

`default_nettype wire

### rtl/core/kmeans_lloyd_cluster_top.sv
`default_nettype none
// Lloyd k-means engine over signed Q16.16 points.
// Input channel (in_valid / in_stall / in_item) carries one request per item:
//   mode 0 writes one coordinate into point memory, taken every cycle while idle, no result;
//   mode 1 copies a stored point into a cluster's start centroid;
//   mode 2 runs the rounds, then streams K*D centroid coordinates, cluster-major,
//   on out_valid / out_item; last marks the final one, converged tells why it stopped.
// Out-of-range indexes and mode 3 are dropped without a result.
// Sums are 32 + log2(MAX_POINTS) + 1 bits wide. A round clears them, assigns and
// accumulates every point, then updates the centroid of each non-empty cluster;
// the divider (one quotient bit a cycle) and pmem's single read port set its pace.
// Each coordinate is emitted only after the previous one has been accepted.
// in_stall is high for the whole run; the next request is taken once the last
// result has been accepted. While out_stall is high the result holds in place.
// Reset clears control state and config (K=1, D=1, N=1, 300 rounds,
// epsilon_sq=4295); point and centroid memories hold nothing valid until written.
// Config writes (cfg_we, cfg_index, cfg_data) belong in idle periods only.

module kmeans_lloyd_cluster_top #(
    parameter int MAX_POINTS   = 4096,
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIM      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  kml_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output kml_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [kml_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kml_pkg::CFG_W-1:0]     cfg_data
);

    import kml_pkg::*;

    localparam int P_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int C_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int J_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    dp_cmd_t        cmd;      // per-cycle step for the datapath
    dp_stat_t       stat;     // divider busy, empty cluster, moved, result taken
    logic [P_W-1:0] p_idx;    // current point
    logic [C_W-1:0] c_idx;    // current cluster
    logic [J_W-1:0] j_idx;    // current coordinate
    logic [47:0]    eps;

    // sequencer: loops over rounds, points, clusters, coordinates
    kml_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIM      (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .p_idx     (p_idx),
        .c_idx     (c_idx),
        .j_idx     (j_idx),
        .eps       (eps)
    );

    // memories, distance unit, divider, output register
    kml_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIM      (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .p_idx     (p_idx),
        .c_idx     (c_idx),
        .j_idx     (j_idx),
        .eps       (eps),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
